### rtl/cad_pkg.sv
`timescale 1ns / 1ps

package cad_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_LOAD     = 2'd1,
        ACT_EXCHANGE = 2'd2,
        ACT_DECIDE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        MOVE_NONE  = 3'd0,
        MOVE_NORTH = 3'd1,
        MOVE_WEST  = 3'd2,
        MOVE_EAST  = 3'd3,
        MOVE_SOUTH = 3'd4
    } t_move;

    localparam logic [3:0] SIG_N = 4'b0001;
    localparam logic [3:0] SIG_W = 4'b0010;
    localparam logic [3:0] SIG_E = 4'b0100;
    localparam logic [3:0] SIG_S = 4'b1000;

    typedef struct packed {
        t_action    action;
        logic       own_defect;
        logic [3:0] neighbor_defects;
        logic [3:0] incoming_signals;
        logic [3:0] flip_mask;
    } t_in_item;

    typedef struct packed {
        logic [3:0] signals_out;
        t_move      move_dir;
    } t_out_item;

endpackage

### rtl/cad_move.sv
`timescale 1ns / 1ps

module cad_move (
    input  logic                i_self_defect,
    input  logic [3:0]          i_near_defects,
    input  logic [3:0]          i_signal_bits,
    output cad_pkg::t_move      o_move
);

    logic [2:0]     sig_count;
    cad_pkg::t_move isolated_move;

    assign sig_count = 3'($countones(i_signal_bits));

    always_comb begin
        isolated_move = cad_pkg::MOVE_NONE;
        unique case (sig_count)
            3'd1: begin
                if ((i_signal_bits & cad_pkg::SIG_W) != 4'd0) begin
                    isolated_move = cad_pkg::MOVE_EAST;
                end else if ((i_signal_bits & cad_pkg::SIG_E) != 4'd0) begin
                    isolated_move = cad_pkg::MOVE_WEST;
                end else if ((i_signal_bits & cad_pkg::SIG_N) != 4'd0) begin
                    isolated_move = cad_pkg::MOVE_SOUTH;
                end else begin
                    isolated_move = cad_pkg::MOVE_NORTH;
                end
            end
            3'd2: begin
                if (i_signal_bits == (cad_pkg::SIG_W | cad_pkg::SIG_N)) begin
                    isolated_move = cad_pkg::MOVE_SOUTH;
                end else if (i_signal_bits == (cad_pkg::SIG_E | cad_pkg::SIG_N)) begin
                    isolated_move = cad_pkg::MOVE_WEST;
                end else begin
                    isolated_move = cad_pkg::MOVE_NONE;
                end
            end
            3'd3: begin
                if ((i_signal_bits & cad_pkg::SIG_S) == 4'd0) begin
                    isolated_move = cad_pkg::MOVE_SOUTH;
                end else if ((i_signal_bits & cad_pkg::SIG_W) == 4'd0) begin
                    isolated_move = cad_pkg::MOVE_WEST;
                end else if ((i_signal_bits & cad_pkg::SIG_N) == 4'd0) begin
                    isolated_move = cad_pkg::MOVE_NORTH;
                end else begin
                    isolated_move = cad_pkg::MOVE_EAST;
                end
            end
            default: begin
                isolated_move = cad_pkg::MOVE_NONE;
            end
        endcase
    end

    always_comb begin
        if (!i_self_defect) begin
            o_move = cad_pkg::MOVE_NONE;
        end else if ((i_near_defects & cad_pkg::SIG_E) != 4'd0) begin
            o_move = cad_pkg::MOVE_EAST;
        end else if ((i_near_defects & cad_pkg::SIG_N) != 4'd0) begin
            o_move = cad_pkg::MOVE_NORTH;
        end else if (i_near_defects != 4'd0) begin
            o_move = cad_pkg::MOVE_NONE;
        end else begin
            o_move = isolated_move;
        end
    end

endmodule

### rtl/cad_state.sv
`timescale 1ns / 1ps

module cad_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  cad_pkg::t_in_item   i_item,
    output cad_pkg::t_out_item  o_result
);

    logic           r_self_defect;
    logic [3:0]     r_near_defects;
    logic [3:0]     r_signal_bits;
    logic           n_self_defect;
    logic [3:0]     n_near_defects;
    logic [3:0]     n_signal_bits;
    logic [3:0]     exchanged;
    cad_pkg::t_move move;

    cad_move u_move (
        .i_self_defect  (r_self_defect),
        .i_near_defects (r_near_defects),
        .i_signal_bits  (r_signal_bits),
        .o_move         (move)
    );

    always_comb begin
        if (!r_self_defect && ($countones(i_item.incoming_signals) > 1)) begin
            exchanged = {i_item.incoming_signals[0], i_item.incoming_signals[1],
                         i_item.incoming_signals[2], i_item.incoming_signals[3]};
        end else begin
            exchanged = i_item.incoming_signals;
        end
    end

    always_comb begin
        n_self_defect  = r_self_defect;
        n_near_defects = r_near_defects;
        n_signal_bits  = r_signal_bits;
        unique case (i_item.action)
            cad_pkg::ACT_CLEAR: begin
                n_self_defect  = 1'b0;
                n_near_defects = 4'd0;
                n_signal_bits  = 4'd0;
            end
            cad_pkg::ACT_LOAD: begin
                n_self_defect  = i_item.own_defect;
                n_near_defects = i_item.neighbor_defects;
                if (i_item.own_defect) begin
                    if ((r_signal_bits & (cad_pkg::SIG_W | cad_pkg::SIG_E)) == 4'd0) begin
                        n_signal_bits = n_signal_bits | cad_pkg::SIG_W | cad_pkg::SIG_E;
                    end
                    if ((r_signal_bits & (cad_pkg::SIG_N | cad_pkg::SIG_S)) == 4'd0) begin
                        n_signal_bits = n_signal_bits | cad_pkg::SIG_N | cad_pkg::SIG_S;
                    end
                end
            end
            cad_pkg::ACT_EXCHANGE: begin
                n_signal_bits = exchanged ^ i_item.flip_mask;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.signals_out = n_signal_bits;
        o_result.move_dir    = (i_item.action == cad_pkg::ACT_DECIDE) ? move
                                                                      : cad_pkg::MOVE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_defect  <= 1'b0;
            r_near_defects <= 4'd0;
            r_signal_bits  <= 4'd0;
        end else if (i_step) begin
            r_self_defect  <= n_self_defect;
            r_near_defects <= n_near_defects;
            r_signal_bits  <= n_signal_bits;
        end
    end

endmodule

### rtl/ca_decoder_cell_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_in_data  (cad_pkg::t_in_item)
// result    out        o_out_valid / i_out_stall o_out_data (cad_pkg::t_out_item)
//
// One transaction per cycle unless the result stalls; input register, then result register.
// The cell state updates as an item leaves the input register for the result register.
// Synchronous active-low reset clears cell state and both valid flags.
// A stalled result holds both registers; one item still enters when the input stage is empty.

module ca_decoder_cell_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cad_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cad_pkg::t_out_item  o_out_data
);

    logic               r_in_valid;
    cad_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    cad_pkg::t_out_item r_out_data;
    cad_pkg::t_out_item result;
    logic               out_free;
    logic               advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    cad_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
